// File: rtl/lps_pkg.sv
// like pattern segmenter package: record and phase types, byte constants,
// record builder functions shared by the step logic and the top level
// no dependencies

package lps_pkg;

    // width of the saturating skip counter
    localparam int SKIP_BITS = 8;
    localparam logic [SKIP_BITS-1:0] SKIP_MAX = {SKIP_BITS{1'b1}};
    localparam int SKIP_WIDE = SKIP_BITS + 8;

    // records produced per pattern byte at most
    localparam int MAX_RECS = 3;

    // wildcard bytes
    localparam logic [7:0] PCT_BYTE = 8'h25;
    localparam logic [7:0] UND_BYTE = 8'h5F;

    // record kinds
    typedef enum logic [1:0] {
        KIND_LIT = 2'd0,
        KIND_END = 2'd1,
        KIND_ERR = 2'd2
    } kind_t;

    // error codes
    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_BAD_ESC = 2'd1,
        ERR_END_ESC = 2'd2
    } err_t;

    // parser phase, one-hot
    typedef enum logic [5:0] {
        PH_INITIAL = 6'b000001,
        PH_MULTI   = 6'b000010,
        PH_SINGLE  = 6'b000100,
        PH_ESCAPE  = 6'b001000,
        PH_LITERAL = 6'b010000,
        PH_ERROR   = 6'b100000
    } phase_t;

    // one result record
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  literal_value;
        logic [7:0]  skip_count;
        logic        open_ended;
        err_t        error_code;
        logic        pattern_done;
        logic        last_of_run;
    } rec_t;

    // parser state
    typedef struct packed {
        phase_t                phase;
        logic [SKIP_BITS-1:0]  skip;
        logic                  open;
    } pstate_t;

    // skip shown on a record, saturated to eight bits
    function automatic logic [7:0] skip_out(input logic [SKIP_BITS-1:0] s);
        logic [SKIP_WIDE-1:0] wide;
        wide = {8'd0, s};
        if (wide > SKIP_WIDE'(255)) begin
            return 8'hFF;
        end
        return wide[7:0];
    endfunction

    function automatic rec_t rec_lit(input logic [7:0] b,
                                     input logic [SKIP_BITS-1:0] s,
                                     input logic o);
        rec_t r;
        r               = '0;
        r.kind          = KIND_LIT;
        r.literal_value = b;
        r.skip_count    = skip_out(s);
        r.open_ended    = o;
        r.error_code    = ERR_NONE;
        return r;
    endfunction

    function automatic rec_t rec_end(input logic [SKIP_BITS-1:0] s, input logic o);
        rec_t r;
        r            = '0;
        r.kind       = KIND_END;
        r.skip_count = skip_out(s);
        r.open_ended = o;
        r.error_code = ERR_NONE;
        return r;
    endfunction

    function automatic rec_t rec_err(input err_t e);
        rec_t r;
        r            = '0;
        r.kind       = KIND_ERR;
        r.error_code = e;
        return r;
    endfunction

endpackage

// File: rtl/lps_step.sv
// one parser step: records caused by a pattern byte and the next parser state
// depends on lps_pkg

module lps_step (
    input  lps_pkg::pstate_t  cur,
    input  logic [7:0]        escape_char,
    input  logic [7:0]        pattern_byte,
    input  logic              end_of_pattern,
    output lps_pkg::pstate_t  nxt,
    output lps_pkg::rec_t     recs [lps_pkg::MAX_RECS],
    output logic [1:0]        rec_cnt
);

    logic is_esc;
    logic is_pct;
    logic is_und;

    assign is_esc = (escape_char != 8'd0) && (pattern_byte == escape_char);
    assign is_pct = (pattern_byte == lps_pkg::PCT_BYTE);
    assign is_und = (pattern_byte == lps_pkg::UND_BYTE);

    // byte handling, then finalization on the last byte
    always_comb begin
        logic [1:0] n;
        n   = 2'd0;
        nxt = cur;
        for (int i = 0; i < lps_pkg::MAX_RECS; i++) begin
            recs[i] = '0;
        end

        if (cur.phase == lps_pkg::PH_ERROR) begin
            // discard the rest of the pattern
            if (end_of_pattern) begin
                nxt.phase = lps_pkg::PH_INITIAL;
                nxt.skip  = '0;
                nxt.open  = 1'b0;
            end
        end else begin
            case (cur.phase)
                lps_pkg::PH_ESCAPE: begin
                    if (is_esc || is_pct || is_und) begin
                        recs[n]   = lps_pkg::rec_lit(pattern_byte, cur.skip, cur.open);
                        n         = n + 2'd1;
                        nxt.phase = lps_pkg::PH_LITERAL;
                    end else begin
                        recs[n]   = lps_pkg::rec_err(lps_pkg::ERR_BAD_ESC);
                        n         = n + 2'd1;
                        nxt.phase = lps_pkg::PH_ERROR;
                    end
                end
                lps_pkg::PH_LITERAL: begin
                    if (is_esc) begin
                        nxt.phase = lps_pkg::PH_ESCAPE;
                    end else if (is_pct) begin
                        recs[n]   = lps_pkg::rec_end(cur.skip, cur.open);
                        n         = n + 2'd1;
                        nxt.skip  = '0;
                        nxt.open  = 1'b1;
                        nxt.phase = lps_pkg::PH_MULTI;
                    end else if (is_und) begin
                        recs[n]   = lps_pkg::rec_end(cur.skip, cur.open);
                        n         = n + 2'd1;
                        nxt.skip  = lps_pkg::SKIP_BITS'(1);
                        nxt.open  = 1'b0;
                        nxt.phase = lps_pkg::PH_SINGLE;
                    end else begin
                        recs[n] = lps_pkg::rec_lit(pattern_byte, cur.skip, cur.open);
                        n       = n + 2'd1;
                    end
                end
                default: begin
                    // initial, after percent, after underscore
                    if (is_esc) begin
                        nxt.phase = lps_pkg::PH_ESCAPE;
                    end else if (is_pct) begin
                        nxt.open  = 1'b1;
                        nxt.phase = lps_pkg::PH_MULTI;
                    end else if (is_und) begin
                        if (cur.skip != lps_pkg::SKIP_MAX) begin
                            nxt.skip = cur.skip + 1'b1;
                        end
                        nxt.phase = lps_pkg::PH_SINGLE;
                    end else begin
                        recs[n]   = lps_pkg::rec_lit(pattern_byte, cur.skip, cur.open);
                        n         = n + 2'd1;
                        nxt.phase = lps_pkg::PH_LITERAL;
                    end
                end
            endcase

            // finalize the pattern
            if (end_of_pattern) begin
                case (nxt.phase)
                    lps_pkg::PH_MULTI, lps_pkg::PH_SINGLE: begin
                        recs[n] = lps_pkg::rec_end(nxt.skip, nxt.open);
                        n       = n + 2'd1;
                    end
                    lps_pkg::PH_ESCAPE: begin
                        recs[n] = lps_pkg::rec_err(lps_pkg::ERR_END_ESC);
                        n       = n + 2'd1;
                    end
                    lps_pkg::PH_LITERAL: begin
                        recs[n] = lps_pkg::rec_end(nxt.skip, nxt.open);
                        n       = n + 2'd1;
                        recs[n] = lps_pkg::rec_end('0, 1'b0);
                        n       = n + 2'd1;
                    end
                    default: begin
                    end
                endcase
                nxt.phase = lps_pkg::PH_INITIAL;
                nxt.skip  = '0;
                nxt.open  = 1'b0;
            end
        end

        // mark the last record of this byte
        if (n != 2'd0) begin
            recs[n - 2'd1].last_of_run  = 1'b1;
            recs[n - 2'd1].pattern_done = end_of_pattern;
        end
        rec_cnt = n;
    end

endmodule

// File: rtl/like_pattern_segmenter_top.sv
// like pattern segmenter top level: stream ports, parser state, record holding
// stage and output register; depends on lps_pkg and lps_step
//
// latency: with the output free, a byte's first record is out in the cycle after acceptance
// throughput: one byte per cycle while the receiver is ready and each byte yields at most
//   one record; a byte yielding more holds off the next until the holding stage drains
// reset: aresetn low clears the parser state, the escape byte and all valid flags

module like_pattern_segmenter_top (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write: escape_char
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // pattern input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] pattern_byte
    input  logic        s_tlast,    // end_of_pattern
    // segment records
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] literal_value, [15:8] skip_count,
                                    // [16] open_ended, [18:17] error_code,
                                    // [19] pattern_done, [23:20] zero
    output logic [1:0]  m_tuser,    // record_kind
    output logic        m_tlast     // last_of_run
);

    logic [7:0]         esc_reg;
    lps_pkg::pstate_t   st_reg;
    lps_pkg::pstate_t   st_next;
    lps_pkg::rec_t      hold_reg  [lps_pkg::MAX_RECS];
    lps_pkg::rec_t      hold_next [lps_pkg::MAX_RECS];
    logic [1:0]         hold_cnt_reg;
    logic [1:0]         hold_cnt_next;
    lps_pkg::rec_t      out_reg;
    lps_pkg::rec_t      out_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    lps_pkg::rec_t      recs [lps_pkg::MAX_RECS];
    logic [1:0]         rec_cnt;
    logic               s_xfer;
    logic               out_free;

    assign cfg_ready = 1'b1;
    assign s_tready  = (hold_cnt_reg == 2'd0);
    assign s_xfer    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // parser step
    lps_step u_step (
        .cur            (st_reg),
        .escape_char    (esc_reg),
        .pattern_byte   (s_tdata),
        .end_of_pattern (s_tlast),
        .nxt            (st_next),
        .recs           (recs),
        .rec_cnt        (rec_cnt)
    );

    // record routing: holding stage drains first, new records go straight out if free
    always_comb begin
        hold_next      = hold_reg;
        hold_cnt_next  = hold_cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (out_free && (hold_cnt_reg != 2'd0)) begin
            out_next       = hold_reg[0];
            out_valid_next = 1'b1;
            hold_next[0]   = hold_reg[1];
            hold_next[1]   = hold_reg[2];
            hold_cnt_next  = hold_cnt_reg - 2'd1;
        end else if (s_xfer) begin
            if (out_free && (rec_cnt != 2'd0)) begin
                out_next       = recs[0];
                out_valid_next = 1'b1;
                hold_next[0]   = recs[1];
                hold_next[1]   = recs[2];
                hold_cnt_next  = rec_cnt - 2'd1;
            end else begin
                hold_next     = recs;
                hold_cnt_next = rec_cnt;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            esc_reg       <= 8'd0;
            st_reg.phase  <= lps_pkg::PH_INITIAL;
            st_reg.skip   <= '0;
            st_reg.open   <= 1'b0;
            hold_cnt_reg  <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                esc_reg <= cfg_data;
            end
            if (s_xfer) begin
                st_reg <= st_next;
            end
            hold_cnt_reg  <= hold_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // record payload
    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    // output packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last_of_run;
    assign m_tdata  = {4'd0, out_reg.pattern_done, out_reg.error_code,
                       out_reg.open_ended, out_reg.skip_count, out_reg.literal_value};

endmodule

// File: sim/testbench.sv
// self-checking testbench for like_pattern_segmenter_top: directed and random patterns,
// records predicted by a scoreboard class and compared field by field
// depends on lps_pkg and the rtl of like_pattern_segmenter_top

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 1000;
    localparam logic [7:0] BSL_BYTE = 8'h5C;

    typedef logic [7:0] byte_q_t[$];

    // predicts segment records from accepted pattern bytes and checks the output stream
    class segment_scoreboard;
        logic [7:0]                    escape_byte;
        lps_pkg::phase_t               parse_phase;
        logic [lps_pkg::SKIP_BITS-1:0] skip_run;
        logic                          open_flag;
        lps_pkg::rec_t                 expected_recs[$];
        int                            errors;

        function new();
            escape_byte = 8'h00;
            errors      = 0;
            clear_pattern();
        endfunction

        function void clear_pattern();
            parse_phase = lps_pkg::PH_INITIAL;
            skip_run    = '0;
            open_flag   = 1'b0;
        endfunction

        function int pending();
            return expected_recs.size();
        endfunction

        // record with the skip clipped to eight bits
        function lps_pkg::rec_t make_rec(lps_pkg::kind_t k, logic [7:0] lit,
                                         logic [lps_pkg::SKIP_BITS-1:0] s,
                                         logic o, lps_pkg::err_t e);
            lps_pkg::rec_t r;
            int unsigned   wide;
            wide            = s;
            r               = '0;
            r.kind          = k;
            r.literal_value = lit;
            r.skip_count    = (wide > 255) ? 8'hFF : 8'(wide);
            r.open_ended    = o;
            r.error_code    = e;
            return r;
        endfunction

        // advance the parser by one byte and queue the records it yields
        function void note_byte(logic [7:0] b, logic last);
            lps_pkg::rec_t recs[$];
            logic          is_esc;
            is_esc = (escape_byte != 8'h00) && (b == escape_byte);
            if (parse_phase == lps_pkg::PH_ERROR) begin
                if (last) clear_pattern();
                return;
            end
            case (parse_phase)
                lps_pkg::PH_ESCAPE: begin
                    if (is_esc || b == lps_pkg::PCT_BYTE || b == lps_pkg::UND_BYTE) begin
                        recs.push_back(make_rec(lps_pkg::KIND_LIT, b, skip_run, open_flag,
                                                lps_pkg::ERR_NONE));
                        parse_phase = lps_pkg::PH_LITERAL;
                    end else begin
                        recs.push_back(make_rec(lps_pkg::KIND_ERR, 8'h00, '0, 1'b0,
                                                lps_pkg::ERR_BAD_ESC));
                        parse_phase = lps_pkg::PH_ERROR;
                    end
                end
                lps_pkg::PH_LITERAL: begin
                    if (is_esc) begin
                        parse_phase = lps_pkg::PH_ESCAPE;
                    end else if (b == lps_pkg::PCT_BYTE) begin
                        recs.push_back(make_rec(lps_pkg::KIND_END, 8'h00, skip_run, open_flag,
                                                lps_pkg::ERR_NONE));
                        skip_run    = '0;
                        open_flag   = 1'b1;
                        parse_phase = lps_pkg::PH_MULTI;
                    end else if (b == lps_pkg::UND_BYTE) begin
                        recs.push_back(make_rec(lps_pkg::KIND_END, 8'h00, skip_run, open_flag,
                                                lps_pkg::ERR_NONE));
                        skip_run    = lps_pkg::SKIP_BITS'(1);
                        open_flag   = 1'b0;
                        parse_phase = lps_pkg::PH_SINGLE;
                    end else begin
                        recs.push_back(make_rec(lps_pkg::KIND_LIT, b, skip_run, open_flag,
                                                lps_pkg::ERR_NONE));
                    end
                end
                default: begin
                    if (is_esc) begin
                        parse_phase = lps_pkg::PH_ESCAPE;
                    end else if (b == lps_pkg::PCT_BYTE) begin
                        open_flag   = 1'b1;
                        parse_phase = lps_pkg::PH_MULTI;
                    end else if (b == lps_pkg::UND_BYTE) begin
                        // saturating wildcard count
                        if (skip_run != lps_pkg::SKIP_MAX) skip_run = skip_run + 1'b1;
                        parse_phase = lps_pkg::PH_SINGLE;
                    end else begin
                        recs.push_back(make_rec(lps_pkg::KIND_LIT, b, skip_run, open_flag,
                                                lps_pkg::ERR_NONE));
                        parse_phase = lps_pkg::PH_LITERAL;
                    end
                end
            endcase
            // finalize on the last byte of the pattern
            if (last) begin
                case (parse_phase)
                    lps_pkg::PH_MULTI, lps_pkg::PH_SINGLE: begin
                        recs.push_back(make_rec(lps_pkg::KIND_END, 8'h00, skip_run, open_flag,
                                                lps_pkg::ERR_NONE));
                    end
                    lps_pkg::PH_ESCAPE: begin
                        recs.push_back(make_rec(lps_pkg::KIND_ERR, 8'h00, '0, 1'b0,
                                                lps_pkg::ERR_END_ESC));
                    end
                    lps_pkg::PH_LITERAL: begin
                        recs.push_back(make_rec(lps_pkg::KIND_END, 8'h00, skip_run, open_flag,
                                                lps_pkg::ERR_NONE));
                        recs.push_back(make_rec(lps_pkg::KIND_END, 8'h00, '0, 1'b0,
                                                lps_pkg::ERR_NONE));
                    end
                    default: begin
                    end
                endcase
                clear_pattern();
            end
            if (recs.size() > 0) begin
                recs[recs.size()-1].last_of_run = 1'b1;
                if (last) recs[recs.size()-1].pattern_done = 1'b1;
            end
            foreach (recs[i]) expected_recs.push_back(recs[i]);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t ns  mismatch: %s", $time, msg);
        endtask

        task check_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        // compare one accepted record transaction with the oldest expectation
        task check_record(logic [1:0] kind, logic [23:0] data, logic last);
            lps_pkg::rec_t want;
            if (expected_recs.size() == 0) begin
                report($sformatf("record with nothing expected, kind %0d data %h", kind, data));
                return;
            end
            want = expected_recs.pop_front();
            check_field("record_kind", 8'(kind), 8'(want.kind));
            check_field("literal_value", data[7:0], want.literal_value);
            check_field("skip_count", data[15:8], want.skip_count);
            check_field("open_ended", 8'(data[16]), 8'(want.open_ended));
            check_field("error_code", 8'(data[18:17]), 8'(want.error_code));
            check_field("pattern_done", 8'(data[19]), 8'(want.pattern_done));
            check_field("pad bits", 8'(data[23:20]), 8'h00);
            check_field("last_of_run", 8'(last), 8'(want.last_of_run));
        endtask
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = 8'h00;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;  // [7:0] pattern_byte
    logic        s_tlast   = 1'b0;   // end_of_pattern
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;            // [7:0] literal_value, [15:8] skip_count, [16] open_ended,
                                     // [18:17] error_code, [19] pattern_done, [23:20] zero
    logic [1:0]  m_tuser;            // record_kind
    logic        m_tlast;            // last_of_run

    segment_scoreboard sb = new();
    logic calm     = 1'b0;
    int   n_sent   = 0;
    int   quiet    = 0;

    like_pattern_segmenter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // clock
    initial begin
        forever #4 aclk = ~aclk;
    end

    // receiver with random stalls, none while calm
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 13);
    end

    // record monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_record(m_tuser, m_tdata, m_tlast);
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("like_pattern_segmenter_top regression: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // one pattern byte, with random idle cycles ahead of it, none while calm
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!calm) begin
            while ($urandom_range(99) < 13) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b, last);
        n_sent++;
    endtask

    task automatic send_seq(input byte_q_t seq);
        foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1);
    endtask

    task automatic send_text(input string txt);
        byte_q_t seq;
        for (int i = 0; i < txt.len(); i++) seq.push_back(txt[i]);
        send_seq(seq);
    endtask

    // hold off the sender until every expected record has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_escape(input logic [7:0] v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.escape_byte = v;
    endtask

    // random byte that is neither a wildcard nor the escape
    function automatic logic [7:0] plain_byte(input logic [7:0] esc);
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255));
        while (b == lps_pkg::PCT_BYTE || b == lps_pkg::UND_BYTE ||
               (esc != 8'h00 && b == esc));
        return b;
    endfunction

    // mostly well-formed patterns with random content, some raw noise
    task automatic send_random_pattern();
        byte_q_t    seq;
        int         len;
        int         tok;
        logic [7:0] esc;
        esc = sb.escape_byte;
        len = $urandom_range(1, 10);
        if ($urandom_range(99) < 80) begin
            while (seq.size() < len) begin
                tok = $urandom_range(0, 9);
                if (tok < 2) begin
                    seq.push_back(lps_pkg::PCT_BYTE);
                end else if (tok < 4) begin
                    seq.push_back(lps_pkg::UND_BYTE);
                end else if (tok < 8 || esc == 8'h00) begin
                    seq.push_back(plain_byte(esc));
                end else begin
                    seq.push_back(esc);
                    case ($urandom_range(0, 2))
                        0: seq.push_back(lps_pkg::PCT_BYTE);
                        1: seq.push_back(lps_pkg::UND_BYTE);
                        default: seq.push_back(esc);
                    endcase
                end
            end
        end else begin
            // noise: stray escapes, bad escapes, patterns ending on an escape
            repeat (len) begin
                if (esc != 8'h00 && $urandom_range(99) < 30) seq.push_back(esc);
                else seq.push_back(8'($urandom_range(1, 255)));
            end
        end
        send_seq(seq);
    endtask

    // one escape setting, with a full drain halfway through
    task automatic run_phase(input logic [7:0] esc, input int quota);
        int start;
        write_escape(esc);
        start = n_sent;
        while (n_sent - start < quota / 2) send_random_pattern();
        settle();
        while (n_sent - start < quota) send_random_pattern();
    endtask

    // stimulus
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // escape disabled after reset: wildcards, extreme bytes, backslash as literal
        send_text("%");
        send_byte(lps_pkg::UND_BYTE, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(lps_pkg::PCT_BYTE, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("\\_");

        // backslash escape: escaped wildcards, bad escape, ending on an escape
        write_escape(BSL_BYTE);
        send_text("\\%\\_\\\\z");
        send_text("a\\");
        send_text("\\q%b");
        send_text("\\");
        send_text("b\\q");

        // random patterns over several escape settings
        run_phase(BSL_BYTE, 18);
        calm = 1'b1;
        run_phase(8'hFF, 18);
        calm = 1'b0;
        run_phase(lps_pkg::PCT_BYTE, 18);
        run_phase(lps_pkg::UND_BYTE, 18);
        run_phase(8'h01, 18);
        run_phase(8'h00, 18);

        // drain and finish
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("like_pattern_segmenter_top regression: pass");
        end else begin
            $display("like_pattern_segmenter_top regression: fail");
        end
        $finish;
    end

endmodule
